// File: hdl/dcl_pkg.sv
// shared types and helpers for the digit code lock
// result record, command codes, register map and the mod-10 reduction
// no dependencies
`default_nettype none

package dcl_pkg;

  // default number of digit positions
  localparam int DCL_MAX_DIGITS = 8;

  // configuration port
  localparam int DCL_ADDR_W = 4;
  localparam int DCL_DATA_W = 32;

  // effective length arithmetic, wide enough for up to 16 positions
  localparam int DCL_LEN_CALC_W = 5;

  typedef enum logic [1:0] {
    CMD_NEW_ATTEMPT = 2'd0,
    CMD_INCREMENT   = 2'd1,
    CMD_CONFIRM     = 2'd2,
    CMD_RESTART     = 2'd3
  } dcl_cmd_t;

  typedef enum logic [1:0] {
    REG_SECRET_DIGITS = 2'd0,
    REG_CODE_LENGTH   = 2'd1,
    REG_ATTEMPT_LIMIT = 2'd2
  } dcl_reg_idx_t;

  typedef struct packed {
    logic [2:0]  lock_status;
    logic [2:0]  digit_position;
    logic [31:0] entered_digits;
    logic [7:0]  attempt_count;
    logic [3:0]  length_in_use;
  } dcl_result_t;

  // 8-bit value mod 10 via reciprocal multiply, exact for values below 1029
  function automatic logic [3:0] dcl_mod10(input logic [7:0] val);
    logic [18:0] prod;
    logic [7:0]  quot;
    logic [11:0] back;
    logic [11:0] rem;
    prod = {11'd0, val} * 19'd205;
    quot = prod[18:11];
    back = {4'd0, quot} * 12'd10;
    rem  = {4'd0, val} - back;
    return rem[3:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/dcl_skid.sv
// two-entry output stage for the digit code lock result channel
// a result register plus one skid entry, ready is registered
// depends on dcl_pkg
`default_nettype none

module dcl_skid (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dcl_pkg::dcl_result_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output dcl_pkg::dcl_result_t      out_data
);
  import dcl_pkg::*;

  logic        out_v_r;
  logic        skid_v_r;
  dcl_result_t out_r;
  dcl_result_t skid_r;
  logic        in_fire;
  logic        out_fire;

  assign in_ready  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign in_fire   = in_valid && !skid_v_r;
  assign out_fire  = out_v_r && out_ready;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_v_r && !out_ready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_v_r && !out_ready) begin
        skid_r <= in_data;
      end else begin
        out_r <= in_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/digit_code_lock_fsm.sv
// top level of the keypad digit code lock
// state machine, digit store and configuration registers; result goes out through dcl_skid
// depends on dcl_pkg and dcl_skid
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------------
//   in        in_valid/in_ready    in_cmd, in_amount
//   out       out_valid/out_ready  out_lock_status, out_digit_position,
//                                  out_entered_digits, out_attempt_count,
//                                  out_length_in_use
//   cfg       psel/penable/pwrite  paddr, pwdata, prdata, pready (always high)
//
// one item per cycle while in_ready is high: the state update is a single pass of
// logic from the accepted command into the state registers and the result register
// a result is registered in the output stage before it shows on out
// the output stage holds two results, so in stalls only when both are taken
// rst_n is synchronous; it returns the lock to idle with a cleared entry
// and restores the register defaults
`default_nettype none

module digit_code_lock_fsm #(
  parameter int MAX_DIGITS = dcl_pkg::DCL_MAX_DIGITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dcl_pkg::DCL_ADDR_W-1:0] paddr,
  input  wire logic [dcl_pkg::DCL_DATA_W-1:0] pwdata,
  output logic      [dcl_pkg::DCL_DATA_W-1:0] prdata,
  output logic                               pready,
  // command channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [7:0]                    in_amount,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_lock_status,
  output logic [2:0]                         out_digit_position,
  output logic [31:0]                        out_entered_digits,
  output logic [7:0]                         out_attempt_count,
  output logic [3:0]                         out_length_in_use
);
  import dcl_pkg::*;

  localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int LEN_W = $clog2(MAX_DIGITS + 1);
  localparam int EXT_W = 4 * MAX_DIGITS + 32;

  // state codes double as the reported status
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_ENTERING = 3'd1,
    ST_WRONG    = 3'd2,
    ST_GRANTED  = 3'd3,
    ST_LOCKED   = 3'd4
  } state_t;

  // configuration registers
  logic [31:0] secret_r;
  logic [3:0]  code_len_r;
  logic [7:0]  limit_r;

  // lock state
  state_t      state_r, state_nxt;
  logic [3:0]  digit_r   [MAX_DIGITS];
  logic [3:0]  digit_nxt [MAX_DIGITS];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  att_r, att_nxt;

  logic        in_fire;
  logic        cfg_wr;
  dcl_cmd_t    cmd;
  dcl_reg_idx_t reg_idx;

  logic [DCL_LEN_CALC_W-1:0] len_raw;
  logic [LEN_W-1:0]          len;
  logic [LEN_W-1:0]          pos_plus;
  logic [8:0]                att_plus;
  logic [3:0]                amt_mod;
  logic [4:0]                dig_sum;
  logic [3:0]                dig_inc;
  logic [EXT_W-1:0]          secret_ext;
  logic [EXT_W-1:0]          packed_ext;
  logic                      match;
  logic [31:0]               pos_ext;

  dcl_result_t res;
  dcl_result_t out_res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = dcl_reg_idx_t'(paddr[3:2]);
  assign cmd     = dcl_cmd_t'(in_cmd);

  // register read-back
  always_comb begin
    case (reg_idx)
      REG_SECRET_DIGITS: prdata = secret_r;
      REG_CODE_LENGTH:   prdata = {28'd0, code_len_r};
      REG_ATTEMPT_LIMIT: prdata = {24'd0, limit_r};
      default:           prdata = '0;
    endcase
  end

  // effective length: zero reads as one, saturate at the store depth
  always_comb begin
    if (code_len_r == 4'd0) begin
      len_raw = DCL_LEN_CALC_W'(1);
    end else if ({1'b0, code_len_r} > DCL_LEN_CALC_W'(MAX_DIGITS)) begin
      len_raw = DCL_LEN_CALC_W'(MAX_DIGITS);
    end else begin
      len_raw = {1'b0, code_len_r};
    end
  end
  assign len = LEN_W'(len_raw);

  assign pos_plus   = LEN_W'(pos_r) + LEN_W'(1);
  assign att_plus   = {1'b0, att_r} + 9'd1;
  assign secret_ext = {(4 * MAX_DIGITS)'(0), secret_r};

  // digit + amount mod 10; stored digits are always below ten
  assign amt_mod = dcl_mod10(in_amount);
  assign dig_sum = {1'b0, digit_r[pos_r]} + {1'b0, amt_mod};
  assign dig_inc = (dig_sum >= 5'd10) ? 4'(dig_sum - 5'd10) : dig_sum[3:0];

  // parallel compare of the positions in use against the secret
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if ((LEN_W'(i) < len) && (digit_r[i] != secret_ext[4*i +: 4])) begin
        match = 1'b0;
      end
    end
  end

  // next state for the accepted command
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    att_nxt   = att_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digit_nxt[i] = digit_r[i];
    end
    case (cmd)
      CMD_NEW_ATTEMPT: begin
        if (state_r inside {ST_ENTERING, ST_WRONG}) begin
          if (att_plus < {1'b0, limit_r}) begin
            state_nxt = ST_ENTERING;
            pos_nxt   = '0;
            att_nxt   = att_plus[7:0];
            for (int i = 0; i < MAX_DIGITS; i++) begin
              digit_nxt[i] = 4'd0;
            end
          end else begin
            state_nxt = ST_LOCKED;
          end
        end
      end
      CMD_INCREMENT: begin
        if (state_r == ST_ENTERING) begin
          digit_nxt[pos_r] = dig_inc;
        end
      end
      CMD_CONFIRM: begin
        if (state_r == ST_IDLE) begin
          state_nxt    = ST_ENTERING;
          pos_nxt      = '0;
          digit_nxt[0] = 4'd0;
        end else if (state_r == ST_ENTERING) begin
          if (pos_plus < len) begin
            // advance and clear the new position
            pos_nxt                    = pos_r + POS_W'(1);
            digit_nxt[pos_r + POS_W'(1)] = 4'd0;
          end else begin
            // last position, or length shrunk under us
            state_nxt = match ? ST_GRANTED : ST_WRONG;
          end
        end
      end
      CMD_RESTART: begin
        state_nxt = ST_IDLE;
        pos_nxt   = '0;
        att_nxt   = 8'd0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
          digit_nxt[i] = 4'd0;
        end
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  // pack the entry; positions beyond the length read as zero
  always_comb begin
    packed_ext = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (LEN_W'(i) < len) begin
        packed_ext[4*i +: 4] = digit_nxt[i];
      end
    end
  end

  assign pos_ext = 32'(pos_nxt);

  always_comb begin
    res.lock_status    = state_nxt;
    res.digit_position = pos_ext[2:0];
    res.entered_digits = packed_ext[31:0];
    res.attempt_count  = att_nxt;
    res.length_in_use  = len_raw[3:0];
  end

  assign in_fire = in_valid && in_ready;

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secret_r   <= 32'd0;
      code_len_r <= 4'd1;
      limit_r    <= 8'd1;
      state_r    <= ST_IDLE;
      pos_r      <= '0;
      att_r      <= 8'd0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digit_r[i] <= 4'd0;
      end
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          REG_SECRET_DIGITS: secret_r   <= pwdata;
          REG_CODE_LENGTH:   code_len_r <= pwdata[3:0];
          REG_ATTEMPT_LIMIT: limit_r    <= pwdata[7:0];
          default: begin
            // unmapped address, write dropped
          end
        endcase
      end
      if (in_fire) begin
        state_r <= state_nxt;
        pos_r   <= pos_nxt;
        att_r   <= att_nxt;
        for (int i = 0; i < MAX_DIGITS; i++) begin
          digit_r[i] <= digit_nxt[i];
        end
      end
    end
  end

  // result register and skid entry
  dcl_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_lock_status    = out_res.lock_status;
  assign out_digit_position = out_res.digit_position;
  assign out_entered_digits = out_res.entered_digits;
  assign out_attempt_count  = out_res.attempt_count;
  assign out_length_in_use  = out_res.length_in_use;

endmodule

`default_nettype wire
